### src/frs_pkg.sv
// ----------------------------------------------------------------------------
// frs_pkg: shared types and constants of the fitness roulette selector
// Sizes of the population ring, field widths, command codes, the control
// state type and the item and result beat structs.
// ----------------------------------------------------------------------------
`default_nettype none

package frs_pkg;

    localparam int MAX_POP   = 64;
    localparam int SLOT_BITS = $clog2(MAX_POP);
    localparam int FIT_BITS  = 32;
    localparam int POP_BITS  = 7;
    localparam int SUM_BITS  = 38;
    localparam int FRAC_BITS = 16;
    localparam int CMD_BITS  = 2;

    localparam logic [POP_BITS-1:0] POP_RESET = POP_BITS'(MAX_POP);

    localparam logic [CMD_BITS-1:0] CMD_LOAD   = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_TALLY  = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_SELECT = 2'd2;
    // The last code is not used; it writes no slot and leaves the statistics alone.
    localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TALLY,
        S_DIV_START,
        S_DIVIDE,
        S_SELECT,
        S_EMIT
    } frs_state_t;

    typedef struct packed {
        logic [CMD_BITS-1:0]  cmd;
        logic [SLOT_BITS-1:0] slot;
        logic [FIT_BITS-1:0]  fitness;
        logic [FRAC_BITS-1:0] random_fraction;
    } frs_item_t;

    typedef struct packed {
        logic [SLOT_BITS-1:0] chosen_slot;
        logic                 chosen_valid;
        logic [SLOT_BITS-1:0] best_slot;
        logic [FIT_BITS-1:0]  best_fitness;
        logic [FIT_BITS-1:0]  worst_fitness;
        logic [SUM_BITS-1:0]  total_fitness;
        logic [FIT_BITS-1:0]  mean_fitness;
    } frs_result_t;

endpackage

`default_nettype wire

### src/frs_cell.sv
// ----------------------------------------------------------------------------
// frs_cell: one population slot of the fitness ring
// Holds one fitness value. A load writes it; a shift takes the value of the
// next cell, so the whole ring rotates one slot toward the head per cycle while shift is high.
// ----------------------------------------------------------------------------
`default_nettype none

module frs_cell (
    input  wire logic                         clk,
    input  wire logic                         shift,
    input  wire logic                         load,
    input  wire logic [frs_pkg::FIT_BITS-1:0] load_data,
    input  wire logic [frs_pkg::FIT_BITS-1:0] neighbor,
    output logic      [frs_pkg::FIT_BITS-1:0] value
);

    logic [frs_pkg::FIT_BITS-1:0] value_reg;
    logic [frs_pkg::FIT_BITS-1:0] value_next;

    always_comb
    begin
        priority if (load)
        begin
            value_next = load_data;
        end
        else if (shift)
        begin
            value_next = neighbor;
        end
        else
        begin
            value_next = value_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

`default_nettype wire

### src/frs_divider.sv
// ----------------------------------------------------------------------------
// frs_divider: iterative restoring divider for the mean
// Divides the tally total by the population size, one quotient bit per
// cycle. The done pulse rises at the edge that stores the last quotient bit.
// ----------------------------------------------------------------------------
`default_nettype none

module frs_divider (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [frs_pkg::SUM_BITS-1:0] dividend,
    input  wire logic [frs_pkg::POP_BITS-1:0] divisor,
    output logic                              done,
    output logic      [frs_pkg::SUM_BITS-1:0] quotient
);

    localparam int CNT_BITS = $clog2(frs_pkg::SUM_BITS);
    localparam logic [CNT_BITS-1:0] LAST_COUNT = CNT_BITS'(frs_pkg::SUM_BITS - 1);

    logic                           busy_reg;
    logic                           busy_next;
    logic                           done_reg;
    logic                           done_next;
    logic [CNT_BITS-1:0]            count_reg;
    logic [CNT_BITS-1:0]            count_next;
    logic [frs_pkg::POP_BITS-1:0]   rem_reg;
    logic [frs_pkg::POP_BITS-1:0]   rem_next;
    logic [frs_pkg::SUM_BITS-1:0]   quo_reg;
    logic [frs_pkg::SUM_BITS-1:0]   quo_next;
    logic [frs_pkg::POP_BITS:0]     rem_shift;
    logic [frs_pkg::POP_BITS:0]     rem_diff;

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        rem_shift  = {rem_reg, quo_reg[frs_pkg::SUM_BITS-1]};
        rem_diff   = rem_shift - {1'b0, divisor};
        if (start)
        begin
            busy_next  = 1'b1;
            count_next = '0;
            rem_next   = '0;
            quo_next   = dividend;
        end
        else if (busy_reg)
        begin
            // The remainder stays below the divisor, so it fits its width.
            if (rem_shift >= {1'b0, divisor})
            begin
                rem_next = rem_diff[frs_pkg::POP_BITS-1:0];
                quo_next = {quo_reg[frs_pkg::SUM_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[frs_pkg::POP_BITS-1:0];
                quo_next = {quo_reg[frs_pkg::SUM_BITS-2:0], 1'b0};
            end
            count_next = count_reg + CNT_BITS'(1);
            if (count_reg == LAST_COUNT)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

### src/fitness_roulette_selector_unit.sv
// ----------------------------------------------------------------------------
// fitness_roulette_selector_unit: roulette wheel selector for a GA population
// Stores 64 fitness values in a rotating ring of cells and runs tally and
// select walks over them, one slot per cycle at the head of the ring.
// ----------------------------------------------------------------------------
// Each item beat carries one command: a load writes one slot, a tally gathers
// total, best, worst and mean over the first pop_size slots (one slot when
// pop_size is 0, 64 when above 64), and a select picks a slot by the running
// sum against random_fraction * total. Every command returns one result beat
// with the chosen slot and the current statistics. pop_size is written through
// cfg_write/cfg_data; the user must write it only while the block is idle; the
// block does not enforce this. A load or unused code goes to the emit step, then
// the result register; a select runs the 64-step ring rotation, then the emit
// step and result register; a tally runs the rotation, then starts, runs and
// unloads the bit-serial divider, then emit step and result register. Commands
// are taken only in idle. The result register holds its beat while result_stall
// is high; a new command can enter meanwhile but waits in its emit step. Reset
// clears the statistics and sets pop_size to 64; slots are undefined until set.
// ----------------------------------------------------------------------------
`default_nettype none

module fitness_roulette_selector_unit (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_write,
    input  wire logic [frs_pkg::POP_BITS-1:0] cfg_data,
    input  wire logic                         item_valid,
    output logic                              item_stall,
    input  wire frs_pkg::frs_item_t           item,
    output logic                              result_valid,
    input  wire logic                         result_stall,
    output frs_pkg::frs_result_t              result
);

    localparam int SLOT_BITS = frs_pkg::SLOT_BITS;
    localparam int FIT_BITS  = frs_pkg::FIT_BITS;
    localparam int SUM_BITS  = frs_pkg::SUM_BITS;
    localparam int POP_BITS  = frs_pkg::POP_BITS;
    localparam int FRAC_BITS = frs_pkg::FRAC_BITS;
    localparam int PROD_BITS = FRAC_BITS + SUM_BITS;
    localparam logic [SLOT_BITS-1:0] LAST_STEP = SLOT_BITS'(frs_pkg::MAX_POP - 1);

    frs_pkg::frs_state_t      state_reg;
    frs_pkg::frs_state_t      state_next;
    logic [POP_BITS-1:0]      pop_size_reg;
    logic [SLOT_BITS-1:0]     step_reg;
    logic [SLOT_BITS-1:0]     step_next;
    logic [SUM_BITS-1:0]      sum_reg;
    logic [SUM_BITS-1:0]      sum_next;
    logic [FIT_BITS-1:0]      top_value_reg;
    logic [FIT_BITS-1:0]      top_value_next;
    logic [SLOT_BITS-1:0]     top_slot_reg;
    logic [SLOT_BITS-1:0]     top_slot_next;
    logic [FIT_BITS-1:0]      bottom_reg;
    logic [FIT_BITS-1:0]      bottom_next;
    logic [FIT_BITS-1:0]      mean_reg;
    logic [FIT_BITS-1:0]      mean_next;
    logic [SUM_BITS-1:0]      slice_reg;
    logic [SUM_BITS-1:0]      slice_next;
    logic [SUM_BITS-1:0]      running_reg;
    logic [SUM_BITS-1:0]      running_next;
    logic [SLOT_BITS-1:0]     chosen_reg;
    logic [SLOT_BITS-1:0]     chosen_next;
    logic                     found_reg;
    logic                     found_next;
    logic                     result_valid_reg;
    logic                     result_valid_next;
    frs_pkg::frs_result_t     result_reg;
    frs_pkg::frs_result_t     result_next;

    logic [POP_BITS-1:0]      used_slots;
    logic                     step_active;
    logic                     ring_shift;
    logic                     cell_load;
    logic [FIT_BITS-1:0]      head;
    logic [SUM_BITS-1:0]      head_ext;
    logic [SUM_BITS-1:0]      run_sum;
    logic [PROD_BITS-1:0]     product;
    logic                     div_start;
    logic                     div_done;
    logic [SUM_BITS-1:0]      div_quotient;
    logic                     emit_ok;

    logic [FIT_BITS-1:0]      cell_value [frs_pkg::MAX_POP];

    // Ring of slots: cell 0 is the head, and every shift moves slot k+1 into
    // cell k. A full rotation brings every value back to its home cell.
    for (genvar g = 0; g < frs_pkg::MAX_POP; g++)
    begin : g_ring
        frs_cell u_cell (
            .clk       (clk),
            .shift     (ring_shift),
            .load      (cell_load && (item.slot == SLOT_BITS'(g))),
            .load_data (item.fitness),
            .neighbor  (cell_value[(g + 1) % frs_pkg::MAX_POP]),
            .value     (cell_value[g])
        );
    end

    frs_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (used_slots),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb
    begin
        priority if (pop_size_reg == '0)
        begin
            used_slots = POP_BITS'(1);
        end
        else if (pop_size_reg > POP_BITS'(frs_pkg::MAX_POP))
        begin
            used_slots = POP_BITS'(frs_pkg::MAX_POP);
        end
        else
        begin
            used_slots = pop_size_reg;
        end
    end

    assign head        = cell_value[0];
    assign head_ext    = SUM_BITS'(head);
    assign step_active = POP_BITS'(step_reg) < used_slots;
    assign run_sum     = running_reg + head_ext;
    assign product     = PROD_BITS'(item.random_fraction) * PROD_BITS'(sum_reg);
    assign emit_ok     = !result_valid_reg || !result_stall;

    always_comb
    begin
        state_next        = state_reg;
        step_next         = step_reg;
        sum_next          = sum_reg;
        top_value_next    = top_value_reg;
        top_slot_next     = top_slot_reg;
        bottom_next       = bottom_reg;
        mean_next         = mean_reg;
        slice_next        = slice_reg;
        running_next      = running_reg;
        chosen_next       = chosen_reg;
        found_next        = found_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg;
        ring_shift        = 1'b0;
        cell_load         = 1'b0;
        div_start         = 1'b0;

        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            frs_pkg::S_IDLE:
            begin
                if (item_valid)
                begin
                    chosen_next = '0;
                    found_next  = 1'b0;
                    step_next   = '0;
                    unique case (item.cmd)
                        frs_pkg::CMD_LOAD:
                        begin
                            cell_load  = 1'b1;
                            state_next = frs_pkg::S_EMIT;
                        end
                        frs_pkg::CMD_TALLY:
                        begin
                            sum_next       = '0;
                            top_value_next = '0;
                            bottom_next    = '1;
                            mean_next      = '0;
                            state_next     = frs_pkg::S_TALLY;
                        end
                        frs_pkg::CMD_SELECT:
                        begin
                            slice_next   = product[FRAC_BITS +: SUM_BITS];
                            running_next = '0;
                            state_next   = frs_pkg::S_SELECT;
                        end
                        default:
                        begin
                            state_next = frs_pkg::S_EMIT;
                        end
                    endcase
                end
            end

            frs_pkg::S_TALLY:
            begin
                ring_shift = 1'b1;
                step_next  = step_reg + SLOT_BITS'(1);
                if (step_active)
                begin
                    if (head > top_value_reg)
                    begin
                        top_value_next = head;
                        top_slot_next  = step_reg;
                    end
                    if (head < bottom_reg)
                    begin
                        bottom_next = head;
                    end
                    sum_next = sum_reg + head_ext;
                end
                if (step_reg == LAST_STEP)
                begin
                    state_next = frs_pkg::S_DIV_START;
                end
            end

            frs_pkg::S_DIV_START:
            begin
                div_start  = 1'b1;
                state_next = frs_pkg::S_DIVIDE;
            end

            frs_pkg::S_DIVIDE:
            begin
                if (div_done)
                begin
                    mean_next  = div_quotient[FIT_BITS-1:0];
                    state_next = frs_pkg::S_EMIT;
                end
            end

            frs_pkg::S_SELECT:
            begin
                ring_shift = 1'b1;
                step_next  = step_reg + SLOT_BITS'(1);
                // The search stops at the first hit; the ring still rotates home.
                if (step_active && !found_reg)
                begin
                    running_next = run_sum;
                    if (run_sum >= slice_reg)
                    begin
                        chosen_next = step_reg;
                        found_next  = 1'b1;
                    end
                end
                if (step_reg == LAST_STEP)
                begin
                    state_next = frs_pkg::S_EMIT;
                end
            end

            frs_pkg::S_EMIT:
            begin
                if (emit_ok)
                begin
                    result_valid_next          = 1'b1;
                    result_next.chosen_slot    = chosen_reg;
                    result_next.chosen_valid   = found_reg;
                    result_next.best_slot      = top_slot_reg;
                    result_next.best_fitness   = top_value_reg;
                    result_next.worst_fitness  = bottom_reg;
                    result_next.total_fitness  = sum_reg;
                    result_next.mean_fitness   = mean_reg;
                    state_next                 = frs_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = frs_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= frs_pkg::S_IDLE;
            pop_size_reg     <= frs_pkg::POP_RESET;
            step_reg         <= '0;
            sum_reg          <= '0;
            top_value_reg    <= '0;
            top_slot_reg     <= '0;
            bottom_reg       <= '1;
            mean_reg         <= '0;
            chosen_reg       <= '0;
            found_reg        <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            step_reg         <= step_next;
            sum_reg          <= sum_next;
            top_value_reg    <= top_value_next;
            top_slot_reg     <= top_slot_next;
            bottom_reg       <= bottom_next;
            mean_reg         <= mean_next;
            chosen_reg       <= chosen_next;
            found_reg        <= found_next;
            result_valid_reg <= result_valid_next;
            if (cfg_write)
            begin
                pop_size_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        slice_reg   <= slice_next;
        running_reg <= running_next;
        result_reg  <= result_next;
    end

    assign item_stall   = (state_reg != frs_pkg::S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // The ring must be back at home position whenever a command can enter.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == frs_pkg::S_IDLE) |-> (step_reg == '0))
        else $error("ring step counter not at home while idle");

    // A hit can only be found during a select walk.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(found_reg) |-> ($past(state_reg) == frs_pkg::S_SELECT))
        else $error("selection hit raised outside a select walk");

    // The total always covers the best single fitness.
    assert property (@(posedge clk) disable iff (!rst_n)
        SUM_BITS'(top_value_reg) <= sum_reg)
        else $error("best fitness exceeds the total");

    // A new result beat appears only from the emit step.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> ($past(state_reg) == frs_pkg::S_EMIT))
        else $error("result beat raised outside the emit step");

endmodule

`default_nettype wire
